// File: src/bit_ngram_frequency_ranker_macros.svh
// Assertion macros for the n-gram ranker.
// Used by the top level only.
`ifndef BIT_NGRAM_FREQUENCY_RANKER_MACROS_SVH
`define BIT_NGRAM_FREQUENCY_RANKER_MACROS_SVH
// implication checked every clock, off in reset
`define BNF_ASSERT_IMP(label, a, c) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (c)) \
		else $error("assertion failed");
// next-cycle implication
`define BNF_ASSERT_NEXT(label, a, c) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (c)) \
		else $error("assertion failed");
`endif

// File: src/bnf_pkg.sv
// Package for the n-gram ranker: sequencer state type, register indexes, op codes
// and the longest pattern length. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package bnf_pkg;
	localparam int MAX_PATTERN_LEN = 12;

	localparam logic [1:0] REG_MIN_LEN = 2'd0;
	localparam logic [1:0] REG_MAX_LEN = 2'd1;
	localparam logic [1:0] REG_GROUPS  = 2'd2;

	localparam logic OP_BIT   = 1'b0;
	localparam logic OP_FETCH = 1'b1;

	typedef enum logic [8:0] {
		ST_CLEAR = 9'b000000001,
		ST_IDLE  = 9'b000000010,
		ST_UPD_R = 9'b000000100,
		ST_UPD_W = 9'b000001000,
		ST_NXT   = 9'b000010000,
		ST_MAX   = 9'b000100000,
		ST_FIRST = 9'b001000000,
		ST_OUT   = 9'b010000000,
		ST_RDW   = 9'b100000000
	} state_t;
endpackage
`default_nettype wire

// File: src/bnf_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module bnf_ram #(
	parameter int WIDTH = 20,
	parameter int DEPTH = 8192
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	always_ff @(posedge clk) begin
		if (we) mem[addr] <= wdata;
		rdata <= mem[addr];
	end
endmodule
`default_nettype wire

// File: src/bit_ngram_frequency_ranker.sv
// Top level of the n-gram ranker: sequencer around one histogram RAM.
// Depends on bnf_pkg, bnf_ram and the macros header.
//
//  channel | signals                                        | role
//  in      | in_valid in_ready op bit_value                 | bit or fetch word
//  out     | out_valid out_ready frequency .. done_res      | ranked result word
//  cfg     | cfg_we cfg_index cfg_wdata                     | register writes
//
// Reset: a clearing pass zeroes the RAM.
// Bit word: each counted length takes an address, a read wait and a write step
// through the single RAM port.
// Fetch word: each scan visits one slot per cycle (RAM port bound): a
// continue scan plus, on a group change, a max scan and a first-match scan.
// The result sits in an output register; a new word is taken while it
// waits except a fetch.
`timescale 1ns / 1ps
`default_nettype none
`include "bit_ngram_frequency_ranker_macros.svh"
module bit_ngram_frequency_ranker
	import bnf_pkg::*;
#(
	parameter int COUNT_BITS = 20
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        op,
	input  wire logic        bit_value,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [COUNT_BITS-1:0]      frequency,
	output logic [3:0]       pattern_length,
	output logic [MAX_PATTERN_LEN-1:0] pattern_bits,
	output logic             group_first,
	output logic             done_res,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [6:0]  cfg_wdata
);
	localparam int AW = MAX_PATTERN_LEN + 1;
	localparam int LW = $clog2(MAX_PATTERN_LEN + 1) + 1;
	localparam logic [AW-1:0] SLOT_LAST = {AW{1'b1}};
	localparam logic [COUNT_BITS-1:0] CMAX = {COUNT_BITS{1'b1}};
	localparam logic [LW-1:0] PLEN = LW'(MAX_PATTERN_LEN);

	state_t state_q;
	logic [3:0] min_q, max_q;
	logic [6:0] groups_q, emitted_q;
	logic [MAX_PATTERN_LEN-1:0] hist_q, lval_q;
	logic [LW-1:0] seen_q, len_q, hi_q, llen_q;
	logic fetched_q, rdone_q, first_q;
	logic [COUNT_BITS-1:0] cur_q, best_q;
	logic [AW-1:0] addr_q, hit_q;
	logic we;
	logic [COUNT_BITS-1:0] wdata, rdata;
	logic [AW-1:0] nslot;
	logic [LW-1:0] slen;
	logic [LW-1:0] lo_c, hi_c, mx_c, seen_n;

	bnf_ram #(.WIDTH(COUNT_BITS), .DEPTH(2 ** AW)) u_ram (
		.clk(clk), .we(we), .addr(addr_q), .wdata(wdata), .rdata(rdata)
	);

	assign in_ready = (state_q == ST_IDLE) && !(op == OP_FETCH && out_valid);

	// slot for the current length during a bit update
	always_comb begin
		nslot = '0;
		nslot[len_q[$clog2(AW)-1:0]] = 1'b1;
		for (int i = 0; i < MAX_PATTERN_LEN; i++)
			if (i < int'(len_q)) nslot[i] = hist_q[i];
	end

	// length of a scanned slot: position of its top set bit
	always_comb begin
		slen = '0;
		for (int i = 1; i < AW; i++)
			if (hit_q[i]) slen = LW'(i);
	end

	assign lo_c = (min_q == 4'd0) ? LW'(1) : LW'(min_q);
	assign mx_c = (LW'(max_q) > PLEN) ? PLEN : LW'(max_q);
	assign seen_n = (seen_q < PLEN) ? seen_q + LW'(1) : seen_q;
	assign hi_c = (mx_c > seen_n) ? seen_n : mx_c;
	assign we = (state_q == ST_CLEAR) || (state_q == ST_UPD_W && rdata != CMAX);
	assign wdata = (state_q == ST_CLEAR) ? '0 : rdata + COUNT_BITS'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			min_q <= 4'd1; max_q <= 4'd12; groups_q <= 7'd20;
			hist_q <= '0; seen_q <= '0; fetched_q <= 1'b0; rdone_q <= 1'b0;
			cur_q <= '0; llen_q <= '0; lval_q <= '0; emitted_q <= '0;
			addr_q <= '0; out_valid <= 1'b0;
			len_q <= '0; hi_q <= '0; best_q <= '0; hit_q <= '0; first_q <= 1'b0;
			frequency <= '0; pattern_length <= '0; pattern_bits <= '0;
			group_first <= 1'b0; done_res <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_MIN_LEN: min_q <= cfg_wdata[3:0];
					REG_MAX_LEN: max_q <= cfg_wdata[3:0];
					REG_GROUPS: groups_q <= cfg_wdata;
					default: ;
				endcase
			end
			if (out_valid && out_ready) out_valid <= 1'b0;
			unique case (state_q)
				ST_CLEAR: begin
					addr_q <= addr_q + AW'(1);
					if (addr_q == SLOT_LAST) state_q <= ST_IDLE;
				end
				ST_IDLE: if (in_valid && in_ready) begin
					if (op == OP_BIT) begin
						if (!fetched_q) begin
							hist_q <= {hist_q[MAX_PATTERN_LEN-2:0], bit_value};
							seen_q <= seen_n;
							len_q <= lo_c;
							hi_q <= hi_c;
							if (lo_c <= hi_c) state_q <= ST_UPD_R;
						end
					end else begin
						fetched_q <= 1'b1;
						if (rdone_q) begin
							first_q <= 1'b0; hit_q <= '0; state_q <= ST_RDW;
						end else if (llen_q != '0) begin
							// start just past the last slot; wraps to zero after the top slot
							addr_q <= ({{(AW-1){1'b0}}, 1'b1} << llen_q[$clog2(AW)-1:0])
								+ AW'(lval_q) + AW'(1);
							hit_q <= '0;
							state_q <= ST_NXT;
						end else begin
							state_q <= ST_MAX;
							addr_q <= AW'(2); best_q <= '0; hit_q <= '0;
						end
					end
				end
				ST_UPD_R: begin
					addr_q <= nslot;
					state_q <= ST_RDW;
					first_q <= 1'b1;
				end
				ST_RDW: begin
					// wait for the registered read; goes on to the write step on a bit update, else to the output
					if (state_q == ST_RDW && first_q && !fetched_q) state_q <= ST_UPD_W;
					else state_q <= ST_OUT;
				end
				ST_UPD_W: begin
					if (len_q == hi_q) state_q <= ST_IDLE;
					else begin
						len_q <= len_q + LW'(1);
						state_q <= ST_UPD_R;
					end
				end
				ST_NXT: begin
					// rdata and hit_q are both registered from addr_q; hit_q names the slot rdata holds
					if (hit_q >= AW'(2) && rdata == cur_q) begin
						first_q <= 1'b0; state_q <= ST_OUT;
					end else if (hit_q == SLOT_LAST || (hit_q == '0 && addr_q == '0)) begin
						if (emitted_q >= groups_q) begin
							hit_q <= '0; first_q <= 1'b0; state_q <= ST_OUT;
							rdone_q <= 1'b1;
						end else begin
							state_q <= ST_MAX; addr_q <= AW'(2); best_q <= '0;
							hit_q <= '0;
						end
					end else begin
						hit_q <= addr_q;
						if (addr_q != '0) addr_q <= addr_q + AW'(1);
					end
				end
				ST_MAX: begin
					hit_q <= addr_q;
					if (addr_q != '0) addr_q <= addr_q + AW'(1);
					if (hit_q >= AW'(2) && rdata > best_q &&
						(emitted_q == '0 || rdata < cur_q)) best_q <= rdata;
					if (hit_q == SLOT_LAST) begin
						if (emitted_q >= groups_q ||
							(best_q == '0 && !(rdata > best_q &&
							(emitted_q == '0 || rdata < cur_q)))) begin
							hit_q <= '0; first_q <= 1'b0; rdone_q <= 1'b1;
							state_q <= ST_OUT;
						end else begin
							if (rdata > best_q && (emitted_q == '0 || rdata < cur_q))
								cur_q <= rdata;
							else cur_q <= best_q;
							emitted_q <= emitted_q + 7'd1;
							addr_q <= AW'(2); hit_q <= '0;
							state_q <= ST_FIRST;
						end
					end
				end
				ST_FIRST: begin
					if (hit_q >= AW'(2) && rdata == cur_q) begin
						first_q <= 1'b1; state_q <= ST_OUT;
					end else begin
						hit_q <= addr_q;
						if (addr_q != '0) addr_q <= addr_q + AW'(1);
					end
				end
				ST_OUT: if (!out_valid || out_ready) begin
					out_valid <= 1'b1;
					if (hit_q == '0) begin
						done_res <= 1'b1; frequency <= '0; pattern_length <= '0;
						pattern_bits <= '0; group_first <= 1'b0; rdone_q <= 1'b1;
					end else begin
						done_res <= 1'b0; frequency <= cur_q;
						pattern_length <= 4'(slen);
						pattern_bits <= MAX_PATTERN_LEN'(hit_q & ~(AW'(1) << slen));
						group_first <= first_q;
						llen_q <= slen;
						lval_q <= MAX_PATTERN_LEN'(hit_q & ~(AW'(1) << slen));
					end
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`BNF_ASSERT_IMP(a_ready_idle, in_ready, state_q == ST_IDLE)
	`BNF_ASSERT_IMP(a_done_zero, out_valid && done_res, pattern_length == 4'd0)
	`BNF_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
endmodule
`default_nettype wire
